>>> sv/pixel_format_converter_defines.svh
// Assertion macros for the pixel format converter.
// Expects clk and rst_n in the scope of each use.
`ifndef PIXEL_FORMAT_CONVERTER_DEFINES_SVH
`define PIXEL_FORMAT_CONVERTER_DEFINES_SVH
`ifndef NO_ASSERTIONS
// Consequent must hold in the same cycle as the antecedent.
`define PFC_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pixel_format_converter: assertion failed");
// Consequent must hold in the cycle after the antecedent.
`define PFC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pixel_format_converter: assertion failed");
`else
`define PFC_ASSERT_SAME(label, ante, cons)
`define PFC_ASSERT_NEXT(label, ante, cons)
`endif
`endif

>>> sv/pfc_pkg.sv
// Shared types, constants and channel geometry functions of the pixel format converter.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pfc_pkg;

  localparam int unsigned PALETTE_DEPTH = 256;
  localparam int unsigned PAL_AW        = $clog2(PALETTE_DEPTH);
  localparam int unsigned PIXEL_W       = 32;
  localparam int unsigned INDEX_W       = 8;
  localparam int unsigned COLOR_W       = 24;
  localparam int unsigned CHAN_W        = 8;
  localparam int unsigned MODE_W        = 2;
  localparam int unsigned CFG_IDX_W     = 3;
  localparam int unsigned CFG_DATA_W    = 32;

  typedef enum logic [MODE_W-1:0] {
    MODE_WRITE   = 2'd0,
    MODE_DIRECT  = 2'd1,
    MODE_PALETTE = 2'd2
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SRC_RED   = 3'd0,
    CFG_SRC_GREEN = 3'd1,
    CFG_SRC_BLUE  = 3'd2,
    CFG_SRC_ALPHA = 3'd3,
    CFG_DST_RED   = 3'd4,
    CFG_DST_GREEN = 3'd5,
    CFG_DST_BLUE  = 3'd6,
    CFG_DST_ALPHA = 3'd7
  } cfg_index_t;

  // Shift is the trailing-zero count, width the first run of ones clamped at 8.
  typedef struct packed {
    logic [4:0] shift;
    logic [3:0] width;
  } chan_geom_t;

  typedef struct packed {
    chan_geom_t alpha;
    chan_geom_t red;
    chan_geom_t green;
    chan_geom_t blue;
  } fmt_geom_t;

  typedef struct packed {
    fmt_geom_t src;
    fmt_geom_t dst;
  } cfg_geom_t;

  typedef struct packed {
    logic [CHAN_W-1:0] alpha;
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } chan_vals_t;

  // Stage 1 control: item in flight, palette lookup, index beyond the table.
  typedef struct packed {
    logic valid;
    logic pal;
    logic oor;
  } s1_ctrl_t;

  // Geometry of the reset masks 0x00ff0000, 0x0000ff00, 0x000000ff, 0xff000000.
  localparam chan_geom_t GEOM_RED_RST   = '{shift: 5'd16, width: 4'd8};
  localparam chan_geom_t GEOM_GREEN_RST = '{shift: 5'd8,  width: 4'd8};
  localparam chan_geom_t GEOM_BLUE_RST  = '{shift: 5'd0,  width: 4'd8};
  localparam chan_geom_t GEOM_ALPHA_RST = '{shift: 5'd24, width: 4'd8};
  localparam fmt_geom_t  FMT_GEOM_RST   = '{alpha: GEOM_ALPHA_RST, red: GEOM_RED_RST,
                                            green: GEOM_GREEN_RST, blue: GEOM_BLUE_RST};

  function automatic chan_geom_t chan_geom(input logic [CFG_DATA_W-1:0] mask);
    chan_geom_t g;
    logic [CFG_DATA_W-1:0] run;
    g.shift = '0;
    for (int i = CFG_DATA_W - 1; i >= 0; i--) begin
      if (mask[i]) g.shift = 5'(i);
    end
    run = mask >> g.shift;
    g.width = 4'd8;
    for (int i = CHAN_W - 1; i >= 0; i--) begin
      if (!run[i]) g.width = 4'(i);
    end
    return g;
  endfunction

  // Pull one channel out of a source pixel, left-justified to 8 bits.
  function automatic logic [CHAN_W-1:0] chan_extract(input logic [PIXEL_W-1:0] px,
                                                     input chan_geom_t g);
    logic [PIXEL_W-1:0] t;
    logic [CHAN_W-1:0]  low_mask;
    logic [CHAN_W-1:0]  v;
    t        = px >> g.shift;
    low_mask = 8'((9'd1 << g.width) - 9'd1);
    v        = t[CHAN_W-1:0] & low_mask;
    return v << (4'd8 - g.width);
  endfunction

  // Keep the top bits of an 8-bit channel and place them; bits above 31 drop.
  function automatic logic [PIXEL_W-1:0] chan_place(input logic [CHAN_W-1:0] c8,
                                                    input chan_geom_t g);
    logic [CHAN_W-1:0] v;
    v = c8 >> (4'd8 - g.width);
    return {24'd0, v} << g.shift;
  endfunction

endpackage

`default_nettype wire

>>> sv/pfc_if.sv
// Request channels of the pixel format converter: input item and result pixel.
// Depends on pfc_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface pfc_in_if;
  import pfc_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [MODE_W-1:0]    mode;
  logic [PIXEL_W-1:0]   pixel_in;
  logic [INDEX_W-1:0]   palette_index;
  logic [COLOR_W-1:0]   entry_color;

  modport source (output valid, mode, pixel_in, palette_index, entry_color, input ready);
  modport sink   (input valid, mode, pixel_in, palette_index, entry_color, output ready);
endinterface

interface pfc_out_if;
  import pfc_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [PIXEL_W-1:0]   pixel_out;

  modport source (output valid, pixel_out, input ready);
  modport sink   (input valid, pixel_out, output ready);
endinterface

`default_nettype wire

>>> sv/pfc_palette_ram.sv
// Palette memory: one write port, one read port with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module pfc_palette_ram #(
  parameter  int unsigned DEPTH = 256,
  parameter  int unsigned WIDTH = 24,
  localparam int unsigned AW    = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
  end

  // Hold read data until the next read.
  always_ff @(posedge clk) begin
    if (re) rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

>>> sv/pfc_cfg_regs.sv
// Configuration registers: channel masks, stored as decoded shift and width.
// Depends on pfc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pfc_cfg_regs (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_we,
  input  wire logic [pfc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [pfc_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output pfc_pkg::cfg_geom_t                   geom
);
  import pfc_pkg::*;

  cfg_geom_t  geom_r;
  cfg_geom_t  geom_nxt;
  chan_geom_t wr_geom;

  // Decode at write time so the datapath sees ready-made geometry.
  always_comb begin
    wr_geom  = chan_geom(cfg_wdata);
    geom_nxt = geom_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_SRC_RED:   geom_nxt.src.red   = wr_geom;
        CFG_SRC_GREEN: geom_nxt.src.green = wr_geom;
        CFG_SRC_BLUE:  geom_nxt.src.blue  = wr_geom;
        CFG_SRC_ALPHA: geom_nxt.src.alpha = wr_geom;
        CFG_DST_RED:   geom_nxt.dst.red   = wr_geom;
        CFG_DST_GREEN: geom_nxt.dst.green = wr_geom;
        CFG_DST_BLUE:  geom_nxt.dst.blue  = wr_geom;
        CFG_DST_ALPHA: geom_nxt.dst.alpha = wr_geom;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      geom_r <= '{src: FMT_GEOM_RST, dst: FMT_GEOM_RST};
    end else begin
      geom_r <= geom_nxt;
    end
  end

  assign geom = geom_r;

endmodule

`default_nettype wire

>>> sv/pfc_unpack.sv
// Unpack stage: source pixel or palette color into four 8-bit channels.
// Depends on pfc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pfc_unpack (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          adv,
  input  wire pfc_pkg::s1_ctrl_t             s1,
  input  wire logic [pfc_pkg::PIXEL_W-1:0]   pixel,
  input  wire logic [pfc_pkg::COLOR_W-1:0]   rd_color,
  input  wire pfc_pkg::fmt_geom_t            src_geom,
  output logic                               s2_valid,
  output pfc_pkg::chan_vals_t                s2_chans
);
  import pfc_pkg::*;

  logic                s2_valid_r;
  chan_vals_t          s2_chans_r;
  chan_vals_t          chans_nxt;
  logic [COLOR_W-1:0]  rgb;

  always_comb begin
    rgb = s1.oor ? '0 : rd_color;
    if (s1.pal) begin
      chans_nxt.alpha = '0;
      chans_nxt.red   = rgb[23:16];
      chans_nxt.green = rgb[15:8];
      chans_nxt.blue  = rgb[7:0];
    end else begin
      chans_nxt.alpha = chan_extract(pixel, src_geom.alpha);
      chans_nxt.red   = chan_extract(pixel, src_geom.red);
      chans_nxt.green = chan_extract(pixel, src_geom.green);
      chans_nxt.blue  = chan_extract(pixel, src_geom.blue);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (adv) begin
      s2_valid_r <= s1.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s1.valid) s2_chans_r <= chans_nxt;
  end

  assign s2_valid = s2_valid_r;
  assign s2_chans = s2_chans_r;

endmodule

`default_nettype wire

>>> sv/pfc_pack.sv
// Pack stage: place channels into the destination format; drives the output register.
// Depends on pfc_pkg and pfc_out_if.
`timescale 1ns / 1ps
`default_nettype none

module pfc_pack (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                adv,
  input  wire logic                s2_valid,
  input  wire pfc_pkg::chan_vals_t s2_chans,
  input  wire pfc_pkg::fmt_geom_t  dst_geom,
  pfc_out_if.source                out_chan
);
  import pfc_pkg::*;

  logic               valid_r;
  logic [PIXEL_W-1:0] pixel_r;
  logic [PIXEL_W-1:0] pixel_nxt;

  assign pixel_nxt = chan_place(s2_chans.alpha, dst_geom.alpha) |
                     chan_place(s2_chans.red,   dst_geom.red)   |
                     chan_place(s2_chans.green, dst_geom.green) |
                     chan_place(s2_chans.blue,  dst_geom.blue);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s2_valid) pixel_r <= pixel_nxt;
  end

  assign out_chan.valid     = valid_r;
  assign out_chan.pixel_out = pixel_r;

endmodule

`default_nettype wire

>>> sv/pixel_format_converter.sv
// Pixel format converter top level: palette memory, unpack and pack stages.
// Path from accepted request to result valid: palette read register, unpack
// register, output register. Throughput: one request per cycle when not stalled.
// The whole pipeline advances when the output register is empty or being taken.
// Reset clears all valid bits and loads the default ARGB 8888 masks;
// palette contents are not cleared and read as undefined until written.
`timescale 1ns / 1ps
`default_nettype none
`include "pixel_format_converter_defines.svh"

module pixel_format_converter (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  pfc_in_if.sink                               in_chan,
  pfc_out_if.source                            out_chan,
  input  wire logic                            cfg_we,
  input  wire logic [pfc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [pfc_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import pfc_pkg::*;

  cfg_geom_t          geom;
  logic               adv;
  logic               in_accept;
  logic               is_direct;
  logic               is_palette;
  logic               idx_oor;
  logic [PAL_AW-1:0]  pal_addr;
  logic [COLOR_W-1:0] rd_color;

  logic               s1_valid_r;
  logic               s1_pal_r;
  logic               s1_oor_r;
  logic [PIXEL_W-1:0] s1_pixel_r;
  s1_ctrl_t           s1;

  logic               s2_valid;
  chan_vals_t         s2_chans;

  assign adv           = !out_chan.valid || out_chan.ready;
  assign in_chan.ready = adv;
  assign in_accept     = in_chan.valid && adv;
  assign is_direct     = in_chan.mode == MODE_DIRECT;
  assign is_palette    = in_chan.mode == MODE_PALETTE;
  assign idx_oor       = {1'b0, in_chan.palette_index} >= 9'(PALETTE_DEPTH);
  assign pal_addr      = in_chan.palette_index[PAL_AW-1:0];

  pfc_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .geom      (geom)
  );

  // A write lands at the edge that accepts it, before any later read, so no bypass is needed.
  pfc_palette_ram #(
    .DEPTH (PALETTE_DEPTH),
    .WIDTH (COLOR_W)
  ) u_palette (
    .clk   (clk),
    .we    (in_accept && in_chan.mode == MODE_WRITE && !idx_oor),
    .waddr (pal_addr),
    .wdata (in_chan.entry_color),
    .re    (in_accept && is_palette),
    .raddr (pal_addr),
    .rdata (rd_color)
  );

  // Palette writes and the unused mode leave no result: drop them here.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= in_accept && (is_direct || is_palette);
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_pal_r   <= is_palette;
      s1_oor_r   <= idx_oor;
      s1_pixel_r <= in_chan.pixel_in;
    end
  end

  assign s1 = '{valid: s1_valid_r, pal: s1_pal_r, oor: s1_oor_r};

  pfc_unpack u_unpack (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .s1       (s1),
    .pixel    (s1_pixel_r),
    .rd_color (rd_color),
    .src_geom (geom.src),
    .s2_valid (s2_valid),
    .s2_chans (s2_chans)
  );

  pfc_pack u_pack (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .s2_valid (s2_valid),
    .s2_chans (s2_chans),
    .dst_geom (geom.dst),
    .out_chan (out_chan)
  );

  `PFC_ASSERT_NEXT(a_s1_to_s2, s1_valid_r && adv, s2_valid)
  `PFC_ASSERT_NEXT(a_s2_to_out, s2_valid && adv, out_chan.valid)
  `PFC_ASSERT_NEXT(a_no_result_dropped, in_accept && !is_direct && !is_palette, !s1_valid_r)
  `PFC_ASSERT_NEXT(a_stall_holds_pipe, !adv, $stable(s1_valid_r) && $stable(s2_valid))
  `PFC_ASSERT_SAME(a_stall_blocks_input, out_chan.valid && !out_chan.ready, !in_accept)

endmodule

`default_nettype wire

>>> sim/pixel_format_converter_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for pixel_format_converter: directed and random requests
// across many mask formats, each result checked against an in-bench conversion model.
// Depends on pfc_pkg, pfc_if and the converter RTL.

module pixel_format_converter_tb;
  import pfc_pkg::*;

  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam int LATENCY       = 3;
  localparam int STALL_LIMIT   = 2000;
  localparam int RANDOM_PHASES = 12;
  localparam int PHASE_ITEMS   = 150;
  localparam int MAX_REPORTS   = 10;

  // Mask registers in register-index order.
  typedef struct packed {
    logic [PIXEL_W-1:0] src_red;
    logic [PIXEL_W-1:0] src_green;
    logic [PIXEL_W-1:0] src_blue;
    logic [PIXEL_W-1:0] src_alpha;
    logic [PIXEL_W-1:0] dst_red;
    logic [PIXEL_W-1:0] dst_green;
    logic [PIXEL_W-1:0] dst_blue;
    logic [PIXEL_W-1:0] dst_alpha;
  } format_masks_t;

  typedef struct packed {
    logic [PIXEL_W-1:0] pixel;
    logic [MODE_W-1:0]  mode;
    logic [PIXEL_W-1:0] source;
  } pixel_expect_t;

  localparam format_masks_t ARGB8888 = '{32'h00ff0000, 32'h0000ff00, 32'h000000ff,
                                         32'hff000000, 32'h00ff0000, 32'h0000ff00,
                                         32'h000000ff, 32'hff000000};

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  pfc_in_if  in_bus ();
  pfc_out_if out_bus ();

  pixel_format_converter DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_bus),
    .out_chan  (out_bus),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  format_masks_t      active_fmt;
  logic [COLOR_W-1:0] palette_rgb [PALETTE_DEPTH];
  bit                 palette_valid [PALETTE_DEPTH];
  int                 written_indices[$];
  pixel_expect_t      expected_pixels[$];
  pixel_expect_t      oldest_pixel;

  int fail_count;
  int results_checked;
  int requests_sent;
  int formats_loaded;
  int mode_count [4];
  int idle_cycles;
  bit full_rate;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Channel geometry: trailing zeros give the shift, the first run of ones the width.
  function automatic void channel_geometry(input logic [PIXEL_W-1:0] mask,
                                           output int shift, output int width);
    shift = 0;
    width = 0;
    if (mask != '0) begin
      while (!mask[shift]) shift++;
      while (shift + width < PIXEL_W && mask[shift + width]) width++;
    end
    if (width > CHAN_W) width = CHAN_W;
  endfunction

  function automatic logic [CHAN_W-1:0] unpack_channel(input logic [PIXEL_W-1:0] px,
                                                       input logic [PIXEL_W-1:0] mask);
    int shift;
    int width;
    logic [PIXEL_W-1:0] v;
    channel_geometry(mask, shift, width);
    if (width == 0) return '0;
    v = (px >> shift) & ((32'd1 << width) - 32'd1);
    return 8'(v << (CHAN_W - width));
  endfunction

  function automatic logic [PIXEL_W-1:0] pack_channel(input logic [CHAN_W-1:0] c8,
                                                      input logic [PIXEL_W-1:0] mask);
    int shift;
    int width;
    logic [63:0] v;
    channel_geometry(mask, shift, width);
    if (width == 0) return '0;
    v = 64'(c8 >> (CHAN_W - width)) << shift;
    return v[PIXEL_W-1:0];
  endfunction

  // Update the palette copy or queue the converted pixel for one accepted request.
  task automatic convert_request(input logic [MODE_W-1:0] mode, input logic [PIXEL_W-1:0] px,
                                 input logic [INDEX_W-1:0] idx,
                                 input logic [COLOR_W-1:0] color);
    pixel_expect_t      exp_pixel;
    logic [COLOR_W-1:0] rgb;
    exp_pixel.mode = mode;
    case (mode)
      MODE_WRITE: begin
        if (idx < PALETTE_DEPTH) begin
          palette_rgb[idx] = color;
          if (!palette_valid[idx]) begin
            palette_valid[idx] = 1'b1;
            written_indices.push_back(int'(idx));
          end
        end
      end
      MODE_DIRECT: begin
        exp_pixel.source = px;
        exp_pixel.pixel =
          pack_channel(unpack_channel(px, active_fmt.src_alpha), active_fmt.dst_alpha) |
          pack_channel(unpack_channel(px, active_fmt.src_red),   active_fmt.dst_red) |
          pack_channel(unpack_channel(px, active_fmt.src_green), active_fmt.dst_green) |
          pack_channel(unpack_channel(px, active_fmt.src_blue),  active_fmt.dst_blue);
        expected_pixels.push_back(exp_pixel);
      end
      MODE_PALETTE: begin
        rgb = (idx < PALETTE_DEPTH) ? palette_rgb[idx] : '0;
        exp_pixel.source = 32'(idx);
        exp_pixel.pixel = pack_channel(rgb[23:16], active_fmt.dst_red) |
                          pack_channel(rgb[15:8],  active_fmt.dst_green) |
                          pack_channel(rgb[7:0],   active_fmt.dst_blue);
        expected_pixels.push_back(exp_pixel);
      end
      default: ;
    endcase
  endtask

  task automatic send_request(input logic [MODE_W-1:0] mode, input logic [PIXEL_W-1:0] px,
                              input logic [INDEX_W-1:0] idx, input logic [COLOR_W-1:0] color);
    if (!full_rate && $urandom_range(0, 7) == 0) begin
      in_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_bus.valid         <= 1'b1;
    in_bus.mode          <= mode;
    in_bus.pixel_in      <= px;
    in_bus.palette_index <= idx;
    in_bus.entry_color   <= color;
    do @(posedge clk); while (in_bus.ready !== 1'b1);
    requests_sent++;
    mode_count[mode]++;
    convert_request(mode, px, idx, color);
  endtask

  // Hold off until every queued pixel is out, then let the pipeline empty.
  task automatic wait_idle();
    in_bus.valid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (LATENCY + 2) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_index_t index, input logic [CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_wdata <= value;
    @(posedge clk);
  endtask

  task automatic load_format(input format_masks_t f);
    wait_idle();
    write_reg(CFG_SRC_RED,   f.src_red);
    write_reg(CFG_SRC_GREEN, f.src_green);
    write_reg(CFG_SRC_BLUE,  f.src_blue);
    write_reg(CFG_SRC_ALPHA, f.src_alpha);
    write_reg(CFG_DST_RED,   f.dst_red);
    write_reg(CFG_DST_GREEN, f.dst_green);
    write_reg(CFG_DST_BLUE,  f.dst_blue);
    write_reg(CFG_DST_ALPHA, f.dst_alpha);
    cfg_we <= 1'b0;
    active_fmt = f;
    formats_loaded++;
  endtask

  function automatic logic [PIXEL_W-1:0] random_mask();
    logic [63:0] run;
    run = ((64'd1 << $urandom_range(1, 12)) - 64'd1) << $urandom_range(0, 31);
    case ($urandom_range(0, 6))
      0: return '0;
      1: return '1;
      2: return $urandom;
      3: return 32'h80000000;
      4: return run[31:0] | (32'd1 << $urandom_range(0, 31));
      default: return run[31:0];
    endcase
  endfunction

  function automatic format_masks_t random_format();
    return '{random_mask(), random_mask(), random_mask(), random_mask(),
             random_mask(), random_mask(), random_mask(), random_mask()};
  endfunction

  function automatic format_masks_t corner_format(input int k);
    case (k)
      1: return '{32'h0000f800, 32'h000007e0, 32'h0000001f, 32'h00000000,
                  32'h00ff0000, 32'h0000ff00, 32'h000000ff, 32'hff000000};
      2: return '{32'h00ff0000, 32'h0000ff00, 32'h000000ff, 32'hff000000,
                  32'h0000f800, 32'h000007e0, 32'h0000001f, 32'h00000000};
      3: return '{32'hffffffff, 32'h0ff00000, 32'h0003ff00, 32'h80000000,
                  32'h000000ff, 32'h0000ff00, 32'h00ff0000, 32'hf0f00000};
      default: return ARGB8888;
    endcase
  endfunction

  task automatic send_random_request();
    int                 pick;
    logic [PIXEL_W-1:0] px;
    logic [INDEX_W-1:0] idx;
    pick = $urandom_range(0, 99);
    case ($urandom_range(0, 9))
      0: px = '0;
      1: px = '1;
      default: px = $urandom;
    endcase
    if (pick < 45) begin
      send_request(MODE_DIRECT, px, 8'($urandom_range(0, 255)), 24'($urandom));
    end else if (pick < 75 && written_indices.size() != 0) begin
      // look up only entries that were written
      idx = 8'(written_indices[$urandom_range(0, written_indices.size() - 1)]);
      send_request(MODE_PALETTE, px, idx, 24'($urandom));
    end else if (pick < 95) begin
      send_request(MODE_WRITE, px, 8'($urandom_range(0, 255)), 24'($urandom));
    end else begin
      send_request(MODE_UNUSED, px, 8'($urandom_range(0, 255)), 24'($urandom));
    end
  endtask

  task automatic test_default_format();
    send_request(MODE_WRITE,   32'h0,        8'h00, 24'hffffff);
    send_request(MODE_WRITE,   32'h0,        8'hff, 24'h000000);
    send_request(MODE_WRITE,   32'h0,        8'h5a, 24'ha53cf0);
    send_request(MODE_DIRECT,  32'h00000000, 8'h00, 24'h000000);
    send_request(MODE_DIRECT,  32'hffffffff, 8'hff, 24'hffffff);
    send_request(MODE_DIRECT,  32'h80402010, 8'h00, 24'h000000);
    // alpha of a lookup is zero whatever the pixel field holds
    send_request(MODE_PALETTE, 32'hffffffff, 8'h00, 24'h000000);
    send_request(MODE_PALETTE, 32'h00000000, 8'hff, 24'h000000);
    send_request(MODE_PALETTE, 32'h00000000, 8'h5a, 24'h000000);
    // unused mode must leave the palette alone
    send_request(MODE_UNUSED,  32'hdeadbeef, 8'h5a, 24'h000000);
    send_request(MODE_PALETTE, 32'h00000000, 8'h5a, 24'h000000);
    send_request(MODE_WRITE,   32'h0,        8'hff, 24'h123456);
    send_request(MODE_PALETTE, 32'h0,        8'hff, 24'h000000);
  endtask

  task automatic test_mask_corners();
    load_format('{default: 32'h0});
    send_request(MODE_DIRECT,  32'hffffffff, 8'h00, 24'h0);
    send_request(MODE_PALETTE, 32'h0,        8'h00, 24'h0);
    load_format('{default: 32'hffffffff});
    send_request(MODE_DIRECT,  32'ha5c30f69, 8'h00, 24'h0);
    send_request(MODE_PALETTE, 32'h0,        8'h5a, 24'h0);
    // wide runs, split runs and a lone top bit
    load_format('{32'h0003ff00, 32'h0f0f0000, 32'h80000000, 32'h00000000,
                  32'h0000f800, 32'h000007e0, 32'h0000001f, 32'hf0f00000});
    send_request(MODE_DIRECT,  32'hffffffff, 8'h00, 24'h0);
    send_request(MODE_DIRECT,  32'h5a5a5a5a, 8'h00, 24'h0);
    send_request(MODE_PALETTE, 32'h0,        8'h00, 24'h0);
    load_format('{32'h00ff0000, 32'h0000ff00, 32'h000000ff, 32'hff000000,
                  32'h000000ff, 32'h0000ff00, 32'h00ff0000, 32'h00000000});
    send_request(MODE_DIRECT,  32'h12345678, 8'h00, 24'h0);
    send_request(MODE_PALETTE, 32'h0,        8'hff, 24'h0);
  endtask

  task automatic test_random_formats();
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      load_format(phase < 4 ? corner_format(phase) : random_format());
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // drain the pipeline mid-phase now and then
        if (n == PHASE_ITEMS / 2 && phase % 3 == 0) wait_idle();
        send_random_request();
      end
    end
  endtask

  task automatic test_full_rate();
    full_rate = 1'b1;
    load_format(random_format());
    repeat (PHASE_ITEMS) send_random_request();
  endtask

  initial begin
    out_bus.ready <= 1'b1;
    forever begin
      repeat ($urandom_range(0, 9) == 0 ? 150 : $urandom_range(1, 30)) @(posedge clk);
      if (!full_rate) begin
        out_bus.ready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
        out_bus.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_bus.valid && out_bus.ready) begin
      results_checked++;
      if (expected_pixels.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS)
          $display("%0t: unexpected result pixel %08h", $time, out_bus.pixel_out);
      end else begin
        oldest_pixel = expected_pixels.pop_front();
        if (out_bus.pixel_out !== oldest_pixel.pixel) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("%0t: pixel mismatch mode %0d source %08h expected %08h got %08h",
                     $time, oldest_pixel.mode, oldest_pixel.source, oldest_pixel.pixel,
                     out_bus.pixel_out);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t: no request moved for %0d cycles, %0d pixels outstanding", $time,
                 idle_cycles, expected_pixels.size());
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin
    in_bus.valid         <= 1'b0;
    in_bus.mode          <= MODE_WRITE;
    in_bus.pixel_in      <= '0;
    in_bus.palette_index <= '0;
    in_bus.entry_color   <= '0;
    cfg_we               <= 1'b0;
    cfg_index            <= CFG_SRC_RED;
    cfg_wdata            <= '0;
    rst_n                <= 1'b0;
    active_fmt  = ARGB8888;
    full_rate   = 1'b0;
    idle_cycles = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_default_format();
    test_mask_corners();
    test_random_formats();
    test_full_rate();

    wait_idle();
    if (expected_pixels.size() != 0) fail_count++;
    $display("Covered %0d requests (%0d write, %0d direct, %0d lookup, %0d unused) over %0d formats",
             requests_sent, mode_count[MODE_WRITE], mode_count[MODE_DIRECT],
             mode_count[MODE_PALETTE], mode_count[MODE_UNUSED], formats_loaded);
    $display("Compared %0d result pixels, %0d failures", results_checked, fail_count);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+sv
sv/pfc_pkg.sv
sv/pfc_if.sv
sv/pfc_palette_ram.sv
sv/pfc_cfg_regs.sv
sv/pfc_unpack.sv
sv/pfc_pack.sv
sv/pixel_format_converter.sv
sim/pixel_format_converter_tb.sv
